>>> sv/free_list_fit_allocator_unit_assert.svh
// Assertion macros for the free-list allocator.
// Included by the top level; no other dependencies.
`ifndef FREE_LIST_FIT_ALLOCATOR_UNIT_ASSERT_SVH
`define FREE_LIST_FIT_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define FLFA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("allocator assertion failed");
`define FLFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("allocator assertion failed");
`else
`define FLFA_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define FLFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> sv/flfa_pkg.sv
// Shared types and codes for the free-list allocator.
// No dependencies.
package flfa_pkg;

    typedef enum logic [1:0] {
        FIT_FIRST,
        FIT_BEST,
        FIT_WORST,
        FIT_NEXT
    } t_fit_mode;

    typedef enum logic [2:0] {
        ST_REUSED,
        ST_GROWN,
        ST_ZERO,
        ST_NOSPACE,
        ST_FREED,
        ST_FREE_ERR
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FREE_RD,
        S_FREE_WB,
        S_SCAN,
        S_BASE_RD,
        S_BASE_WB,
        S_GROW,
        S_RESULT
    } t_state;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // compare unit result
    typedef struct packed {
        logic        fits;
        logic        better;
        logic [15:0] surplus;
    } t_cmp_res;

endpackage

>>> sv/flfa_ram.sv
// Simple dual-port block table memory: one write port, one registered read.
// No dependencies.
module flfa_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/flfa_fit_cmp.sv
// Shared fit compare unit: checks one table entry against the request
// and against the best candidate so far. Depends on flfa_pkg.
module flfa_fit_cmp (
    input  flfa_pkg::t_fit_mode i_mode,
    input  logic                i_mark,
    input  logic [15:0]         i_size,
    input  logic [15:0]         i_need,
    input  logic                i_found,
    input  logic [15:0]         i_best_surp,
    output flfa_pkg::t_cmp_res  o_res
);

    logic        fits;
    logic [15:0] surplus;
    logic        better;

    always_comb begin
        fits    = i_mark && (i_size >= i_need);
        surplus = i_size - i_need;
        better  = 1'b0;
        if (fits) begin
            case (i_mode)
                flfa_pkg::FIT_BEST:  better = !i_found || (surplus < i_best_surp);
                flfa_pkg::FIT_WORST: better = !i_found || (surplus > i_best_surp);
                default:             better = 1'b1;
            endcase
        end
        o_res = '{fits: fits, better: better, surplus: surplus};
    end

endmodule

>>> sv/free_list_fit_allocator_unit.sv
// Free-list heap allocator top level: sequencer, block state, config port.
// Depends on flfa_pkg, flfa_ram, flfa_fit_cmp and the assertion header.
//
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    tuser: opcode; tdata: request_size, block_id
//  m_axis    out  m_axis_tvalid/tready    tuser: status; tdata: block, offset, size
//  apb       in   psel/penable/pready     fit_mode at byte address 0
//
// Allocate: decode, then one table read per cycle through the shared fit compare
// unit and a drain of the last read, then a base read; first and next fit stop
// at the first hit, a grow skips the base read. Free: decode, table read, write-back.
// Zero size, oversize and unknown-block requests go from decode to the result.
// Reset is synchronous; the block tables need no clearing pass.
// A held result stalls the sequencer in its result state; input waits in idle.
`include "free_list_fit_allocator_unit_assert.svh"

module free_list_fit_allocator_unit #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] request_size, [21:16] block_id
    input  logic        s_axis_tuser,   // [0] opcode
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [5:0] granted_block, [21:6] data_offset,
                                        // [37:22] granted_size
    output logic [2:0]  m_axis_tuser,   // [2:0] status
    // config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;
    localparam int TOP_W = $clog2(HEAP_BYTES + 1);
    localparam int SUM_W = ((TOP_W > 17) ? TOP_W : 17) + 1;

    // control
    flfa_pkg::t_state    r_state, n_state;
    flfa_pkg::t_fit_mode r_fit_mode;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [TOP_W-1:0]    r_top, n_top;
    logic [IDX_W-1:0]    r_cursor, n_cursor;
    logic                r_cur_valid, n_cur_valid;
    logic [MAX_BLOCKS-1:0] r_marks, n_marks;
    logic [CNT_W-1:0]    r_iss, n_iss;
    logic                r_ev_valid, n_ev_valid;
    logic                r_found, n_found;
    logic                r_out_valid, n_out_valid;

    // payload
    logic                r_op, n_op;
    logic [15:0]         r_req, n_req;
    logic [16:0]         r_need, n_need;
    logic [5:0]          r_id, n_id;
    logic [IDX_W-1:0]    r_rd_addr, n_rd_addr;
    logic                r_ev_last, n_ev_last;
    logic [IDX_W-1:0]    r_ev_idx, n_ev_idx;
    logic                r_ev_mark, n_ev_mark;
    logic [IDX_W-1:0]    r_best_idx, n_best_idx;
    logic [15:0]         r_best_size, n_best_size;
    logic [15:0]         r_best_surp, n_best_surp;
    flfa_pkg::t_status   r_res_status, n_res_status;
    logic [5:0]          r_res_block, n_res_block;
    logic [15:0]         r_res_offset, n_res_offset;
    logic [15:0]         r_res_size, n_res_size;
    flfa_pkg::t_status   r_out_status, n_out_status;
    logic [5:0]          r_out_block, n_out_block;
    logic [15:0]         r_out_offset, n_out_offset;
    logic [15:0]         r_out_size, n_out_size;

    logic [15:0]         size_q;
    logic [TOP_W-1:0]    base_q;
    logic                ram_we;
    flfa_pkg::t_cmp_res  cmp;

    logic               accept, out_free, cfg_wr;
    logic               id_bad, grow_ok, issue_en, addr_wrap;
    logic               hit, early, scan_done, sel_found;
    logic [IDX_W-1:0]   sel_idx, start_idx, id_idx, cnt_idx;
    logic [SUM_W-1:0]   grow_sum;
    logic [15:0]        q_offset;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;

    assign s_axis_tready = (r_state == flfa_pkg::S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {2'b00, r_out_size, r_out_offset, r_out_block};
    assign pready        = 1'b1;
    assign prdata        = paddr[2] ? 32'd0 : 32'(r_fit_mode);

    // decode helpers
    assign id_bad   = CMP_W'(r_id) >= CMP_W'(r_count);
    assign id_idx   = IDX_W'(r_id);
    assign cnt_idx  = IDX_W'(r_count);
    assign grow_sum = SUM_W'(r_top) + SUM_W'(HEADER_BYTES) + SUM_W'(r_need);
    assign grow_ok  = (r_count < CNT_W'(MAX_BLOCKS)) && (grow_sum <= SUM_W'(HEAP_BYTES));
    assign start_idx = (r_fit_mode == flfa_pkg::FIT_NEXT && r_cur_valid &&
                        CNT_W'(r_cursor) < r_count) ? r_cursor : '0;
    assign q_offset = 16'(SUM_W'(base_q) + SUM_W'(HEADER_BYTES));

    // scan pipeline: issue a table read, evaluate it in the next cycle
    assign issue_en  = (r_state == flfa_pkg::S_SCAN) && (r_iss < r_count);
    assign addr_wrap = (CNT_W'(r_rd_addr) == r_count - 1'b1);
    assign hit       = r_ev_valid && cmp.better;
    assign early     = hit && (r_fit_mode == flfa_pkg::FIT_FIRST ||
                               r_fit_mode == flfa_pkg::FIT_NEXT);
    assign scan_done = r_ev_valid && (early || r_ev_last);
    assign sel_found = hit || r_found;
    assign sel_idx   = hit ? r_ev_idx : r_best_idx;

    assign ram_we = (r_state == flfa_pkg::S_GROW) && grow_ok;

    flfa_ram #(.DEPTH(MAX_BLOCKS), .WIDTH(16), .ADDR_W(IDX_W)) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (cnt_idx),
        .i_wdata (r_need[15:0]),
        .i_raddr (r_rd_addr),
        .o_rdata (size_q)
    );

    flfa_ram #(.DEPTH(MAX_BLOCKS), .WIDTH(TOP_W), .ADDR_W(IDX_W)) u_base_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (cnt_idx),
        .i_wdata (r_top),
        .i_raddr (r_rd_addr),
        .o_rdata (base_q)
    );

    flfa_fit_cmp u_cmp (
        .i_mode      (r_fit_mode),
        .i_mark      (r_ev_mark),
        .i_size      (size_q),
        .i_need      (r_need[15:0]),
        .i_found     (r_found),
        .i_best_surp (r_best_surp),
        .o_res       (cmp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            flfa_pkg::S_IDLE: begin
                if (accept) n_state = flfa_pkg::S_DECODE;
            end
            flfa_pkg::S_DECODE: begin
                if (r_op == flfa_pkg::OP_FREE) begin
                    n_state = id_bad ? flfa_pkg::S_RESULT : flfa_pkg::S_FREE_RD;
                end else if (r_req == 16'd0 || r_need[16]) begin
                    n_state = flfa_pkg::S_RESULT;
                end else if (r_count == '0) begin
                    n_state = flfa_pkg::S_GROW;
                end else begin
                    n_state = flfa_pkg::S_SCAN;
                end
            end
            flfa_pkg::S_FREE_RD: n_state = flfa_pkg::S_FREE_WB;
            flfa_pkg::S_FREE_WB: n_state = flfa_pkg::S_RESULT;
            flfa_pkg::S_SCAN: begin
                if (scan_done) n_state = sel_found ? flfa_pkg::S_BASE_RD : flfa_pkg::S_GROW;
            end
            flfa_pkg::S_BASE_RD: n_state = flfa_pkg::S_BASE_WB;
            flfa_pkg::S_BASE_WB: n_state = flfa_pkg::S_RESULT;
            flfa_pkg::S_GROW:    n_state = flfa_pkg::S_RESULT;
            flfa_pkg::S_RESULT: begin
                if (out_free) n_state = flfa_pkg::S_IDLE;
            end
            default: n_state = flfa_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count      = r_count;
        n_top        = r_top;
        n_cursor     = r_cursor;
        n_cur_valid  = r_cur_valid;
        n_marks      = r_marks;
        n_iss        = r_iss;
        n_ev_valid   = issue_en;
        n_found      = r_found;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_op         = r_op;
        n_req        = r_req;
        n_need       = r_need;
        n_id         = r_id;
        n_rd_addr    = r_rd_addr;
        n_ev_last    = r_ev_last;
        n_ev_idx     = r_ev_idx;
        n_ev_mark    = r_ev_mark;
        n_best_idx   = r_best_idx;
        n_best_size  = r_best_size;
        n_best_surp  = r_best_surp;
        n_res_status = r_res_status;
        n_res_block  = r_res_block;
        n_res_offset = r_res_offset;
        n_res_size   = r_res_size;
        n_out_status = r_out_status;
        n_out_block  = r_out_block;
        n_out_offset = r_out_offset;
        n_out_size   = r_out_size;
        case (r_state)
            flfa_pkg::S_IDLE: begin
                if (accept) begin
                    n_op   = s_axis_tuser;
                    n_req  = s_axis_tdata[15:0];
                    n_id   = s_axis_tdata[21:16];
                    // round up to a multiple of 4; bit 16 flags oversize
                    n_need = (17'(s_axis_tdata[15:0]) + 17'd3) & ~17'd3;
                end
            end
            flfa_pkg::S_DECODE: begin
                n_res_block  = 6'd0;
                n_res_offset = 16'd0;
                n_res_size   = 16'd0;
                n_rd_addr    = start_idx;
                n_iss        = '0;
                n_found      = 1'b0;
                if (r_op == flfa_pkg::OP_FREE) begin
                    n_res_status = flfa_pkg::ST_FREE_ERR;
                    n_res_block  = r_id;
                    n_rd_addr    = id_idx;
                end else if (r_req == 16'd0) begin
                    n_res_status = flfa_pkg::ST_ZERO;
                end else if (r_need[16]) begin
                    n_res_status = flfa_pkg::ST_NOSPACE;
                end else if (r_count == '0 && r_fit_mode == flfa_pkg::FIT_NEXT) begin
                    n_cursor    = '0;
                    n_cur_valid = 1'b0;
                end
            end
            flfa_pkg::S_FREE_WB: begin
                n_res_status = r_marks[id_idx] ? flfa_pkg::ST_FREE_ERR : flfa_pkg::ST_FREED;
                n_res_block  = r_id;
                n_res_offset = q_offset;
                n_res_size   = size_q;
                n_marks[id_idx] = 1'b1;
            end
            flfa_pkg::S_SCAN: begin
                if (issue_en) begin
                    n_rd_addr = addr_wrap ? '0 : r_rd_addr + 1'b1;
                    n_iss     = r_iss + 1'b1;
                    n_ev_idx  = r_rd_addr;
                    n_ev_mark = r_marks[r_rd_addr];
                    n_ev_last = (r_iss == r_count - 1'b1);
                end
                if (hit) begin
                    n_found     = 1'b1;
                    n_best_idx  = r_ev_idx;
                    n_best_size = size_q;
                    n_best_surp = cmp.surplus;
                end
                if (scan_done) begin
                    n_ev_valid = 1'b0;
                    n_rd_addr  = sel_idx;
                    if (r_fit_mode == flfa_pkg::FIT_NEXT) begin
                        n_cursor    = sel_found ? sel_idx : '0;
                        n_cur_valid = sel_found;
                    end
                end
            end
            flfa_pkg::S_BASE_WB: begin
                n_marks[r_best_idx] = 1'b0;
                n_res_status = flfa_pkg::ST_REUSED;
                n_res_block  = 6'(r_best_idx);
                n_res_offset = q_offset;
                n_res_size   = r_best_size;
            end
            flfa_pkg::S_GROW: begin
                if (grow_ok) begin
                    n_marks[cnt_idx] = 1'b0;
                    n_count      = r_count + 1'b1;
                    n_top        = TOP_W'(grow_sum);
                    n_res_status = flfa_pkg::ST_GROWN;
                    n_res_block  = 6'(r_count);
                    n_res_offset = 16'(SUM_W'(r_top) + SUM_W'(HEADER_BYTES));
                    n_res_size   = r_need[15:0];
                end else begin
                    n_res_status = flfa_pkg::ST_NOSPACE;
                    n_res_block  = 6'd0;
                    n_res_offset = 16'd0;
                    n_res_size   = 16'd0;
                end
            end
            flfa_pkg::S_RESULT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_block  = r_res_block;
                    n_out_offset = r_res_offset;
                    n_out_size   = r_res_size;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= flfa_pkg::S_IDLE;
            r_fit_mode  <= flfa_pkg::FIT_FIRST;
            r_count     <= '0;
            r_top       <= '0;
            r_cursor    <= '0;
            r_cur_valid <= 1'b0;
            r_marks     <= '0;
            r_iss       <= '0;
            r_ev_valid  <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (cfg_wr && !paddr[2]) begin
                r_fit_mode <= flfa_pkg::t_fit_mode'(pwdata[1:0]);
            end
            r_count     <= n_count;
            r_top       <= n_top;
            r_cursor    <= n_cursor;
            r_cur_valid <= n_cur_valid;
            r_marks     <= n_marks;
            r_iss       <= n_iss;
            r_ev_valid  <= n_ev_valid;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_req        <= n_req;
        r_need       <= n_need;
        r_id         <= n_id;
        r_rd_addr    <= n_rd_addr;
        r_ev_last    <= n_ev_last;
        r_ev_idx     <= n_ev_idx;
        r_ev_mark    <= n_ev_mark;
        r_best_idx   <= n_best_idx;
        r_best_size  <= n_best_size;
        r_best_surp  <= n_best_surp;
        r_res_status <= n_res_status;
        r_res_block  <= n_res_block;
        r_res_offset <= n_res_offset;
        r_res_size   <= n_res_size;
        r_out_status <= n_out_status;
        r_out_block  <= n_out_block;
        r_out_offset <= n_out_offset;
        r_out_size   <= n_out_size;
    end

    `FLFA_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_BLOCKS))
    `FLFA_ASSERT_NEXT(a_grow_count, i_clk, i_rst_n, ram_we, r_count == $past(r_count) + 1'b1)
    `FLFA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept,
                      r_state == flfa_pkg::S_DECODE && !s_axis_tready)

endmodule
